>>> design/hbridge_timed_brake_sequencer_macros.svh
// ----------------------------------------------------------------------------
// H-bridge brake sequencer assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef HBRIDGE_TIMED_BRAKE_SEQUENCER_MACROS_SVH
`define HBRIDGE_TIMED_BRAKE_SEQUENCER_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define HBTS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hbts check failed in the same cycle");

// The antecedent implies the consequent in the next cycle.
`define HBTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hbts check failed in the next cycle");

`endif

>>> design/hbts_pkg.sv
// ----------------------------------------------------------------------------
// H-bridge brake sequencer package
// Field widths, command and mode codes and register reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hbts_pkg;

  localparam int unsigned CmdW     = 3;
  localparam int unsigned SpeedW   = 9;
  localparam int unsigned DurW     = 16;
  localparam int unsigned DutyW    = 8;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned ElapsedW = 17;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgIdxW  = 1;

  typedef logic [CmdW-1:0]     cmd_t;
  typedef logic [ModeW-1:0]    mode_t;
  typedef logic [DutyW-1:0]    duty_t;
  typedef logic [DurW-1:0]     dur_t;
  typedef logic [ElapsedW-1:0] elapsed_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;

  // Command codes carried in tuser.
  localparam cmd_t CMD_TICK        = 3'd0;
  localparam cmd_t CMD_DRIVE       = 3'd1;
  localparam cmd_t CMD_DRIVE_TIMED = 3'd2;
  localparam cmd_t CMD_HARD_TIMED  = 3'd3;
  localparam cmd_t CMD_HOLD_SOFT   = 3'd4;
  localparam cmd_t CMD_SOFT_TIMED  = 3'd5;
  localparam cmd_t CMD_FREE        = 3'd6;

  // Operating modes.
  localparam mode_t MODE_FREE         = 3'd0;
  localparam mode_t MODE_MOVING       = 3'd1;
  localparam mode_t MODE_MOVING_TIMED = 3'd2;
  localparam mode_t MODE_HARD_BRAKE   = 3'd3;
  localparam mode_t MODE_SOFT_TIMED   = 3'd4;
  localparam mode_t MODE_HOLD_BRAKE   = 3'd5;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_HARD_HOLD = 1'd0;
  localparam cfg_idx_t CFG_SOFT_HOLD = 1'd1;

  localparam dur_t     HARD_HOLD_RESET = 16'd100;
  localparam dur_t     SOFT_HOLD_RESET = 16'd1000;
  localparam duty_t    FULL_DUTY       = 8'hFF;
  localparam elapsed_t ELAPSED_MAX     = 17'h1FFFF;

endpackage

`default_nettype wire

>>> design/hbridge_timed_brake_sequencer.sv
// ----------------------------------------------------------------------------
// H-bridge timed brake sequencer
// Drives one bridge channel from commands and millisecond ticks, stepping a
// timed drive through hard brake and soft brake to free run.
// ----------------------------------------------------------------------------
//  Channel  Dir  Ports                 Contents
//  in       in   in_t*  tdata, tuser   speed_request, duration_ms; command
//  out      out  out_t* tdata          dir_a, dir_b, enable_duty, mode_now
//  cfg      in   cfg_*                 hold times for hard and soft brake
//
// One transaction is taken per cycle; its result is registered and appears
// on the output channel in the following cycle. The mode and timer update in
// one pass of next-state logic. Input is taken while the result register is
// empty or being emptied, so a stalled output stops input only when full.
// Reset is synchronous and active low and restores the default hold times.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "hbridge_timed_brake_sequencer_macros.svh"

module hbridge_timed_brake_sequencer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // [8:0] speed_request (signed), [24:9] duration_ms, [31:25] zero
  input  wire logic [hbts_pkg::InDataW-1:0]  in_tdata,
  // [2:0] command
  input  wire logic [hbts_pkg::CmdW-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // [0] dir_a, [1] dir_b, [9:2] enable_duty, [12:10] mode_now, [15:13] zero
  output logic [hbts_pkg::OutDataW-1:0]      out_tdata,
  input  wire logic                          cfg_wr_en,
  input  wire logic [hbts_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [hbts_pkg::DurW-1:0]     cfg_wdata
);

  hbts_pkg::dur_t     hard_hold_r, soft_hold_r;
  hbts_pkg::mode_t    mode_r, mode_nxt;
  hbts_pkg::elapsed_t elapsed_r, elapsed_nxt, elapsed_inc;
  hbts_pkg::dur_t     hold_limit_r, hold_limit_nxt;
  logic               pin_a_r, pin_a_nxt, pin_b_r, pin_b_nxt;
  hbts_pkg::duty_t    duty_r, duty_nxt;
  logic               out_valid_r;
  logic [hbts_pkg::OutDataW-1:0] out_tdata_r, out_tdata_nxt;

  logic                            in_accept;
  logic signed [hbts_pkg::SpeedW-1:0] speed;
  hbts_pkg::dur_t                  dur;
  logic [hbts_pkg::SpeedW-1:0]     speed_neg;
  hbts_pkg::duty_t                 drive_duty;
  logic                            drive_a, drive_b;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign speed     = in_tdata[hbts_pkg::SpeedW-1:0];
  assign dur       = in_tdata[hbts_pkg::SpeedW +: hbts_pkg::DurW];

  // Reverse speeds take the magnitude; only -256 overflows eight bits.
  always_comb begin
    speed_neg = -speed;
    if (speed[hbts_pkg::SpeedW-1]) begin
      drive_a    = 1'b0;
      drive_b    = 1'b1;
      drive_duty = speed_neg[hbts_pkg::SpeedW-1] ? hbts_pkg::FULL_DUTY
                                                 : speed_neg[hbts_pkg::DutyW-1:0];
    end else begin
      drive_a    = 1'b1;
      drive_b    = 1'b0;
      drive_duty = speed[hbts_pkg::DutyW-1:0];
    end
  end

  always_comb begin
    mode_nxt       = mode_r;
    elapsed_nxt    = elapsed_r;
    hold_limit_nxt = hold_limit_r;
    pin_a_nxt      = pin_a_r;
    pin_b_nxt      = pin_b_r;
    duty_nxt       = duty_r;
    elapsed_inc    = (elapsed_r == hbts_pkg::ELAPSED_MAX) ? elapsed_r
                                                          : elapsed_r + 1'b1;
    case (in_tuser)
      hbts_pkg::CMD_TICK: begin
        elapsed_nxt = elapsed_inc;
        // The timer has expired once the count passes the limit.
        if (elapsed_inc > {1'b0, hold_limit_r}) begin
          case (mode_r)
            hbts_pkg::MODE_MOVING_TIMED: begin
              mode_nxt       = hbts_pkg::MODE_HARD_BRAKE;
              elapsed_nxt    = '0;
              hold_limit_nxt = hard_hold_r;
              pin_a_nxt      = 1'b1;
              pin_b_nxt      = 1'b1;
              duty_nxt       = hbts_pkg::FULL_DUTY;
            end
            hbts_pkg::MODE_HARD_BRAKE: begin
              mode_nxt       = hbts_pkg::MODE_SOFT_TIMED;
              elapsed_nxt    = '0;
              hold_limit_nxt = soft_hold_r;
              pin_a_nxt      = 1'b0;
              pin_b_nxt      = 1'b0;
              duty_nxt       = hbts_pkg::FULL_DUTY;
            end
            hbts_pkg::MODE_SOFT_TIMED: begin
              mode_nxt  = hbts_pkg::MODE_FREE;
              pin_a_nxt = 1'b0;
              pin_b_nxt = 1'b0;
              duty_nxt  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      hbts_pkg::CMD_DRIVE: begin
        mode_nxt  = hbts_pkg::MODE_MOVING;
        pin_a_nxt = drive_a;
        pin_b_nxt = drive_b;
        duty_nxt  = drive_duty;
      end
      hbts_pkg::CMD_DRIVE_TIMED: begin
        mode_nxt       = hbts_pkg::MODE_MOVING_TIMED;
        elapsed_nxt    = '0;
        hold_limit_nxt = dur;
        pin_a_nxt      = drive_a;
        pin_b_nxt      = drive_b;
        duty_nxt       = drive_duty;
      end
      hbts_pkg::CMD_HARD_TIMED: begin
        mode_nxt       = hbts_pkg::MODE_HARD_BRAKE;
        elapsed_nxt    = '0;
        hold_limit_nxt = dur;
        pin_a_nxt      = 1'b1;
        pin_b_nxt      = 1'b1;
        duty_nxt       = hbts_pkg::FULL_DUTY;
      end
      hbts_pkg::CMD_HOLD_SOFT: begin
        mode_nxt  = hbts_pkg::MODE_HOLD_BRAKE;
        pin_a_nxt = 1'b0;
        pin_b_nxt = 1'b0;
        duty_nxt  = hbts_pkg::FULL_DUTY;
      end
      hbts_pkg::CMD_SOFT_TIMED: begin
        mode_nxt       = hbts_pkg::MODE_SOFT_TIMED;
        elapsed_nxt    = '0;
        hold_limit_nxt = dur;
        pin_a_nxt      = 1'b0;
        pin_b_nxt      = 1'b0;
        duty_nxt       = hbts_pkg::FULL_DUTY;
      end
      hbts_pkg::CMD_FREE: begin
        mode_nxt  = hbts_pkg::MODE_FREE;
        pin_a_nxt = 1'b0;
        pin_b_nxt = 1'b0;
        duty_nxt  = '0;
      end
      default: begin
      end
    endcase
    out_tdata_nxt = {3'b000, mode_nxt, duty_nxt, pin_b_nxt, pin_a_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hard_hold_r  <= hbts_pkg::HARD_HOLD_RESET;
      soft_hold_r  <= hbts_pkg::SOFT_HOLD_RESET;
      mode_r       <= hbts_pkg::MODE_FREE;
      elapsed_r    <= '0;
      hold_limit_r <= '0;
      pin_a_r      <= 1'b0;
      pin_b_r      <= 1'b0;
      duty_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          hbts_pkg::CFG_HARD_HOLD: hard_hold_r <= cfg_wdata;
          hbts_pkg::CFG_SOFT_HOLD: soft_hold_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        mode_r       <= mode_nxt;
        elapsed_r    <= elapsed_nxt;
        hold_limit_r <= hold_limit_nxt;
        pin_a_r      <= pin_a_nxt;
        pin_b_r      <= pin_b_nxt;
        duty_r       <= duty_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_tready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;

  `HBTS_ASSERT_NEXT(a_accept_gives_result, in_accept, out_valid_r)
  `HBTS_ASSERT_SAME(a_result_mode_matches, out_valid_r, out_tdata_r[12:10] == mode_r)
  `HBTS_ASSERT_SAME(a_hard_brake_pins, mode_r == hbts_pkg::MODE_HARD_BRAKE, pin_a_r && pin_b_r && (duty_r == hbts_pkg::FULL_DUTY))
  `HBTS_ASSERT_SAME(a_free_pins, mode_r == hbts_pkg::MODE_FREE, !pin_a_r && !pin_b_r && (duty_r == '0))

endmodule

`default_nettype wire

>>> test/tb_hbridge_timed_brake_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// H-bridge timed brake sequencer testbench
// Sends drive, brake, free run and tick commands and compares every result
// with a cycle-free model of the channel. The model covers the pin levels,
// the duty, the timed mode chain and the hold time registers. Directed
// corner cases come first. Random command and tick sequences follow, under
// several hold time settings, mostly with random stalls on both channels.
// ----------------------------------------------------------------------------

module tb_hbridge_timed_brake_sequencer;
  import hbts_pkg::*;

  localparam cmd_t        CMD_UNUSED  = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 8;

  typedef struct packed {
    logic  dir_a;
    logic  dir_b;
    duty_t duty;
    mode_t mode;
  } bridge_out_t;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [InDataW-1:0]   in_tdata   = '0;
  logic [CmdW-1:0]      in_tuser   = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OutDataW-1:0]  out_tdata;
  logic                 cfg_wr_en  = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index  = '0;
  logic [DurW-1:0]      cfg_wdata  = '0;

  // Model of the channel, updated on every accepted transaction.
  mode_t       chan_mode;
  elapsed_t    chan_elapsed;
  dur_t        chan_limit;
  logic        chan_pin_a;
  logic        chan_pin_b;
  duty_t       chan_duty;
  dur_t        hard_hold;
  dur_t        soft_hold;

  bridge_out_t pin_state_q[$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  bit          no_gaps    = 1'b0;

  hbridge_timed_brake_sequencer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= no_gaps || ($urandom_range(0, 99) >= 16);
  end

  function automatic void set_pins(logic a, logic b, duty_t d);
    chan_pin_a = a;
    chan_pin_b = b;
    chan_duty  = d;
  endfunction

  function automatic void restart_timer(dur_t limit);
    chan_elapsed = '0;
    chan_limit   = limit;
  endfunction

  function automatic void apply_drive(logic [SpeedW-1:0] spd);
    logic [SpeedW-1:0] mag;
    if (spd[SpeedW-1]) begin
      mag = -spd;
      // A request of -256 has a magnitude of 256, which saturates.
      set_pins(1'b0, 1'b1, (mag > FULL_DUTY) ? FULL_DUTY : mag[DutyW-1:0]);
    end else begin
      set_pins(1'b1, 1'b0, spd[DutyW-1:0]);
    end
    chan_mode = MODE_MOVING;
  endfunction

  function automatic void step_channel(cmd_t cmd, logic [SpeedW-1:0] spd, dur_t dur);
    case (cmd)
      CMD_TICK: begin
        if (chan_elapsed != ELAPSED_MAX) chan_elapsed = chan_elapsed + 1'b1;
        if (chan_elapsed > {1'b0, chan_limit}) begin
          case (chan_mode)
            MODE_MOVING_TIMED: begin
              restart_timer(hard_hold);
              set_pins(1'b1, 1'b1, FULL_DUTY);
              chan_mode = MODE_HARD_BRAKE;
            end
            MODE_HARD_BRAKE: begin
              restart_timer(soft_hold);
              set_pins(1'b0, 1'b0, FULL_DUTY);
              chan_mode = MODE_SOFT_TIMED;
            end
            MODE_SOFT_TIMED: begin
              set_pins(1'b0, 1'b0, '0);
              chan_mode = MODE_FREE;
            end
            default: ;
          endcase
        end
      end
      CMD_DRIVE: apply_drive(spd);
      CMD_DRIVE_TIMED: begin
        apply_drive(spd);
        restart_timer(dur);
        chan_mode = MODE_MOVING_TIMED;
      end
      CMD_HARD_TIMED: begin
        restart_timer(dur);
        set_pins(1'b1, 1'b1, FULL_DUTY);
        chan_mode = MODE_HARD_BRAKE;
      end
      CMD_HOLD_SOFT: begin
        set_pins(1'b0, 1'b0, FULL_DUTY);
        chan_mode = MODE_HOLD_BRAKE;
      end
      CMD_SOFT_TIMED: begin
        restart_timer(dur);
        set_pins(1'b0, 1'b0, FULL_DUTY);
        chan_mode = MODE_SOFT_TIMED;
      end
      CMD_FREE: begin
        set_pins(1'b0, 1'b0, '0);
        chan_mode = MODE_FREE;
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Results are checked before new commands are modelled, so a result and a
  // command taken at the same edge are never confused.
  always @(posedge clk) begin
    bridge_out_t got;
    bridge_out_t want;
    if (!rst_n) begin
      chan_mode    = MODE_FREE;
      chan_elapsed = '0;
      chan_limit   = '0;
      set_pins(1'b0, 1'b0, '0);
      hard_hold    = HARD_HOLD_RESET;
      soft_hold    = SOFT_HOLD_RESET;
      pin_state_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.dir_a = out_tdata[0];
        got.dir_b = out_tdata[1];
        got.duty  = out_tdata[9:2];
        got.mode  = out_tdata[12:10];
        if (pin_state_q.size() == 0) begin
          $error("result transaction with no command outstanding: %h", out_tdata);
          mismatches++;
        end else begin
          want = pin_state_q.pop_front();
          check_field("dir_a", want.dir_a, got.dir_a);
          check_field("dir_b", want.dir_b, got.dir_b);
          check_field("enable_duty", want.duty, got.duty);
          check_field("mode_now", want.mode, got.mode);
        end
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_HARD_HOLD: hard_hold = cfg_wdata;
          CFG_SOFT_HOLD: soft_hold = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        step_channel(in_tuser, in_tdata[SpeedW-1:0], in_tdata[SpeedW+DurW-1:SpeedW]);
        want.dir_a = chan_pin_a;
        want.dir_b = chan_pin_b;
        want.duty  = chan_duty;
        want.mode  = chan_mode;
        pin_state_q.push_back(want);
      end
    end
  end

  task automatic send_item(cmd_t cmd, logic [SpeedW-1:0] spd, dur_t dur);
    bit ready_seen;
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < 16) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(InDataW-SpeedW-DurW){1'b0}}, dur, spd};
    // in_tready is settled by the falling edge, ahead of the edge that counts.
    do begin
      @(negedge clk);
      ready_seen = in_tready;
      @(posedge clk);
    end while (!ready_seen);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pin_state_q.size() != 0);
  endtask

  task automatic set_holds(dur_t hard_ms, dur_t soft_ms);
    wait_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_HARD_HOLD;
    cfg_wdata <= hard_ms;
    @(posedge clk);
    cfg_index <= CFG_SOFT_HOLD;
    cfg_wdata <= soft_ms;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [SpeedW-1:0] any_speed();
    return SpeedW'($urandom_range(0, 511));
  endfunction

  task automatic test_directed();
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_DRIVE, 9'd0, '0);
    send_item(CMD_DRIVE, 9'd1, '0);
    send_item(CMD_DRIVE, 9'd255, '0);
    send_item(CMD_DRIVE, -9'sd1, '0);
    send_item(CMD_DRIVE, -9'sd255, '0);
    send_item(CMD_DRIVE, 9'h100, '0);
    // A zero duration ends on the first tick; the hard brake then holds.
    send_item(CMD_DRIVE_TIMED, 9'd100, 16'd0);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_HARD_TIMED, '0, 16'd0);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_SOFT_TIMED, '0, 16'd0);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_HOLD_SOFT, '1, 16'hFFFF);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_SOFT_TIMED, '0, 16'hFFFF);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_HARD_TIMED, '0, 16'd1);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_TICK, '0, '0);
    send_item(CMD_UNUSED, '1, 16'hFFFF);
    send_item(CMD_FREE, '0, '0);
    send_item(CMD_DRIVE_TIMED, 9'h100, 16'hFFFF);
    send_item(CMD_UNUSED, '0, '0);
  endtask

  task automatic test_hold_extremes();
    set_holds('0, '0);
    send_item(CMD_DRIVE_TIMED, -9'sd40, 16'd0);
    repeat (4) send_item(CMD_TICK, '0, '0);
    set_holds('1, '1);
    send_item(CMD_DRIVE_TIMED, 9'd77, 16'd0);
    repeat (3) send_item(CMD_TICK, '0, '0);
    send_item(CMD_HARD_TIMED, '0, 16'd0);
    repeat (2) send_item(CMD_TICK, '0, '0);
  endtask

  // Mostly a timed command followed by a random run of ticks that may walk
  // the brake chain, with stray commands and noise mixed in.
  task automatic run_traffic(int unsigned n_items);
    int unsigned sent;
    int unsigned n_ticks;
    bit          paused;
    cmd_t        cmd;
    dur_t        dur;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      if (!paused && sent >= n_items / 2) begin
        paused = 1'b1;
        wait_idle();
      end
      if ($urandom_range(0, 99) < 70) begin
        case ($urandom_range(0, 2))
          0:       cmd = CMD_DRIVE_TIMED;
          1:       cmd = CMD_HARD_TIMED;
          default: cmd = CMD_SOFT_TIMED;
        endcase
        if ($urandom_range(0, 9) < 9) dur = DurW'($urandom_range(0, 15));
        else dur = DurW'($urandom_range(0, 65535));
        send_item(cmd, any_speed(), dur);
        n_ticks = $urandom_range(0, 40);
        repeat (n_ticks) begin
          if ($urandom_range(0, 19) == 0) cmd = cmd_t'($urandom_range(1, 7));
          else cmd = CMD_TICK;
          send_item(cmd, any_speed(), DurW'($urandom_range(0, 65535)));
        end
        sent += n_ticks + 1;
      end else begin
        send_item(cmd_t'($urandom_range(0, 7)), any_speed(), DurW'($urandom_range(0, 65535)));
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    set_holds(16'd3, 16'd6);
    run_traffic(250);
    set_holds(16'd0, 16'd1);
    run_traffic(150);
    set_holds(DurW'($urandom_range(0, 10)), DurW'($urandom_range(0, 10)));
    run_traffic(200);
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    set_holds(16'd2, 16'd4);
    run_traffic(150);
    no_gaps = 1'b0;
  endtask

  task automatic test_long_soft_hold();
    set_holds(16'd1, 16'hFFFF);
    run_traffic(80);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_hold_extremes();
    test_random_traffic();
    test_back_to_back();
    test_long_soft_hold();
    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
